// ===== hw/rtl/bbl_pkg.sv =====
// Shared types and constants for the box blur line filter.
package bbl_pkg;

  // Width of the count fields in a classified request; it holds counts up to
  // 127 pixels, above any window depth that a 4-bit radius allows.
  localparam int CLS_W = 7;

  // Number of color channels carried per pixel.
  localparam int LANES = 4;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       line_end;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] avg_red;
    logic [7:0] avg_green;
    logic [7:0] avg_blue;
    logic [7:0] avg_alpha;
    logic       out_last;
  } pix_out_t;

  // What the front end decides about one pixel before the back end runs it.
  typedef struct packed {
    logic             emit;
    logic [CLS_W-1:0] pend;
    logic [CLS_W-1:0] seen;
  } cls_t;

  typedef struct packed {
    pix_in_t pixel;
    cls_t    cls;
  } job_t;

endpackage

// ===== hw/rtl/bbl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bbl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 31
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/bbl_front.sv =====
// Front end: accepts pixels, classifies them and queues them for the back end.
module bbl_front
  import bbl_pkg::*;
#(
  parameter int MAX_RADIUS = 15
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       clear,
  input  logic [3:0] radius,
  input  logic       push,
  input  pix_in_t    pixel,
  output logic       full,
  output job_t       job,
  output logic       job_valid,
  input  logic       job_take
);

  localparam int DEPTH_R = 2 * MAX_RADIUS + 1;
  localparam int CNT_W   = $clog2(DEPTH_R + 1);

  logic [CNT_W-1:0] seen;
  logic [CNT_W-1:0] seen_inc;
  logic [CNT_W-1:0] r_ext;
  logic [1:0]       count;
  logic             head;
  logic             tail;
  logic             push_ok;
  logic             take;
  cls_t             cls;
  job_t             q [2];

  assign r_ext    = CNT_W'(radius);
  assign seen_inc = (seen == CNT_W'(DEPTH_R)) ? seen : seen + 1'b1;

  always_comb begin
    cls.emit = (seen_inc > r_ext);
    cls.seen = CLS_W'(seen_inc);
    if (pixel.line_end) begin
      cls.pend = (seen_inc < r_ext) ? CLS_W'(seen_inc) : CLS_W'(r_ext);
    end else begin
      cls.pend = '0;
    end
  end

  assign full      = (count == 2'd2);
  assign push_ok   = push && !full;
  assign job_valid = (count != 2'd0);
  assign take      = job_take && job_valid;
  assign job       = q[head];

  always_ff @(posedge clk) begin
    if (rst) begin
      seen  <= '0;
      count <= '0;
      head  <= 1'b0;
      tail  <= 1'b0;
    end else begin
      if (clear) begin
        seen <= '0;
      end else if (push_ok) begin
        seen <= pixel.line_end ? '0 : seen_inc;
      end
      if (push_ok) begin
        tail <= ~tail;
      end
      if (take) begin
        head <= ~head;
      end
      count <= count + {1'b0, push_ok} - {1'b0, take};
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q[tail] <= '{pixel: pixel, cls: cls};
    end
  end

endmodule

// ===== hw/rtl/bbl_div.sv =====
// Four-lane restoring divider, one quotient bit per cycle, 8-bit quotients.
module bbl_div
  import bbl_pkg::*;
#(
  parameter int CNT_W = 5,
  parameter int SUM_W = 13
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [LANES-1:0][SUM_W-1:0] sums,
  input  logic [CNT_W-1:0]            divisor,
  output logic                        busy,
  output logic [LANES-1:0][7:0]       quot
);

  logic [LANES-1:0][SUM_W-1:0] rem;
  logic [CNT_W-1:0]            div;
  logic [2:0]                  step;
  logic [SUM_W-1:0]            dsh;

  // The quotient is known to stay below 256, so eight steps cover it.
  assign dsh = SUM_W'(div) << step;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= 3'd7;
    end else if (busy) begin
      step <= step - 1'b1;
      if (step == 3'd0) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= sums;
      div  <= divisor;
      quot <= '0;
    end else if (busy) begin
      for (int ln = 0; ln < LANES; ln++) begin
        if (rem[ln] >= dsh) begin
          rem[ln]        <= rem[ln] - dsh;
          quot[ln][step] <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/bbl_back.sv =====
// Back end: running sums, pixel ring, flush sequencing and result register.
module bbl_back
  import bbl_pkg::*;
#(
  parameter int MAX_RADIUS = 15
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       clear,
  input  logic [3:0] radius,
  input  job_t       job,
  input  logic       job_valid,
  output logic       job_take,
  output pix_out_t   result,
  output logic       empty,
  input  logic       pop
);

  localparam int DEPTH_R = 2 * MAX_RADIUS + 1;
  localparam int PTR_W   = (DEPTH_R > 1) ? $clog2(DEPTH_R) : 1;
  localparam int CNT_W   = $clog2(DEPTH_R + 1);
  localparam int SUM_W   = 8 + CNT_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DROP  = 3'd1;
  localparam logic [2:0] S_ADD   = 3'd2;
  localparam logic [2:0] S_FLUSH = 3'd3;
  localparam logic [2:0] S_FDROP = 3'd4;
  localparam logic [2:0] S_START = 3'd5;
  localparam logic [2:0] S_DIV   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]                  state;
  pix_in_t                     pix;
  logic                        emit;
  logic [CNT_W-1:0]            seen;
  logic [CNT_W-1:0]            d;
  logic                        final_out;
  logic [PTR_W-1:0]            ptr;
  logic [CNT_W-1:0]            count;
  logic [LANES-1:0][SUM_W-1:0] sums;
  logic                        out_valid;

  logic [CNT_W-1:0]            r_ext;
  logic [CNT_W-1:0]            fullw;
  logic [CNT_W:0]              dr;
  logic [CNT_W-1:0]            target;
  logic [CNT_W:0]              oldest_w;
  logic [PTR_W-1:0]            oldest;
  logic [31:0]                 wdata;
  logic [31:0]                 rdata;
  logic [LANES-1:0][7:0]       pix_ch;
  logic                        div_busy;
  logic [LANES-1:0][7:0]       quot;
  logic                        load_out;

  assign r_ext  = CNT_W'(radius);
  assign fullw  = CNT_W'({radius, 1'b1});
  assign dr     = (CNT_W + 1)'(d) + (CNT_W + 1)'(r_ext);
  assign target = (dr > (CNT_W + 1)'(seen)) ? seen : CNT_W'(dr);

  // Slot of the oldest pixel in the window.
  always_comb begin
    oldest_w = (CNT_W + 1)'(ptr) + (CNT_W + 1)'(DEPTH_R) - (CNT_W + 1)'(count);
    if (oldest_w >= (CNT_W + 1)'(DEPTH_R)) begin
      oldest_w = oldest_w - (CNT_W + 1)'(DEPTH_R);
    end
    oldest = PTR_W'(oldest_w);
  end

  assign pix_ch = {pix.alpha, pix.blue, pix.green, pix.red};
  assign wdata  = pix_ch;

  bbl_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH_R)
  ) u_ring (
    .clk  (clk),
    .we   (state == S_ADD),
    .waddr(ptr),
    .wdata(wdata),
    .raddr(oldest),
    .rdata(rdata)
  );

  bbl_div #(
    .CNT_W(CNT_W),
    .SUM_W(SUM_W)
  ) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (state == S_START),
    .sums   (sums),
    .divisor(count),
    .busy   (div_busy),
    .quot   (quot)
  );

  assign job_take = (state == S_IDLE) && job_valid && !clear;
  assign load_out = (state == S_OUT) && (!out_valid || pop);
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ptr       <= '0;
      count     <= '0;
      sums      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (clear) begin
        state <= S_IDLE;
        ptr   <= '0;
        count <= '0;
        sums  <= '0;
      end else begin
        case (state)
          S_IDLE: begin
            if (job_valid) begin
              state <= (count >= fullw) ? S_DROP : S_ADD;
            end
          end
          S_DROP, S_FDROP: begin
            for (int ln = 0; ln < LANES; ln++) begin
              sums[ln] <= sums[ln] - SUM_W'(rdata[8*ln +: 8]);
            end
            count <= count - 1'b1;
            state <= (state == S_DROP) ? S_ADD : S_FLUSH;
          end
          S_ADD: begin
            for (int ln = 0; ln < LANES; ln++) begin
              sums[ln] <= sums[ln] + SUM_W'(pix_ch[ln]);
            end
            count <= count + 1'b1;
            ptr   <= (ptr == PTR_W'(DEPTH_R - 1)) ? '0 : ptr + 1'b1;
            if (emit) begin
              state <= S_START;
            end else if (pix.line_end) begin
              state <= S_FLUSH;
            end else begin
              state <= S_IDLE;
            end
          end
          S_FLUSH: begin
            if (d == '0) begin
              // End of line: start the next one from an empty window.
              ptr   <= '0;
              count <= '0;
              sums  <= '0;
              state <= S_IDLE;
            end else if (count > target) begin
              state <= S_FDROP;
            end else begin
              state <= S_START;
            end
          end
          S_START: begin
            state <= S_DIV;
          end
          S_DIV: begin
            if (!div_busy) begin
              state <= S_OUT;
            end
          end
          S_OUT: begin
            if (load_out) begin
              state <= pix.line_end ? S_FLUSH : S_IDLE;
            end
          end
          default: begin
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

  // Request payload and flush bookkeeping.
  always_ff @(posedge clk) begin
    if (job_take) begin
      pix  <= job.pixel;
      emit <= job.cls.emit;
      d    <= CNT_W'(job.cls.pend);
      seen <= CNT_W'(job.cls.seen);
    end
    if (state == S_ADD) begin
      final_out <= pix.line_end && (d == '0);
    end
    if ((state == S_FLUSH) && (d != '0) && !(count > target)) begin
      final_out <= (d == CNT_W'(1));
      d         <= d - 1'b1;
    end
    if (load_out) begin
      result.avg_red   <= quot[0];
      result.avg_green <= quot[1];
      result.avg_blue  <= quot[2];
      result.avg_alpha <= quot[3];
      result.out_last  <= final_out;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH_R))
    else $error("window count exceeds ring depth");

  a_idle_window: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (count <= fullw))
    else $error("window larger than 2*radius+1 between requests");

  a_drop_nonempty: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DROP) || (state == S_FDROP)) |-> (count != '0))
    else $error("dropping a pixel from an empty window");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> !div_busy)
    else $error("result taken before the divider finished");

endmodule

// ===== hw/rtl/box_blur_line_filter.sv =====
// Top level of the box blur line filter: configuration register and two ends.
//
// This block runs one pass of a separable box blur over a line of ARGB
// pixels. Each request carries one pixel and a line_end flag; each result is
// the truncated per-channel mean over pixels x-radius to x+radius, with the
// window clipped at both ends of the line and divided by the number of pixels
// actually inside it. Results lag the input by radius pixels, and the pixel
// that carries line_end flushes the remaining ones, the last of which carries
// out_last. The radius register sits at byte address 0; writing it restarts
// the line, so write it only between lines while the block is idle. A front
// end classifies each pixel and queues it (two entries deep), and a back end
// keeps the running sums and a ring of the last 2*MAX_RADIUS+1 pixels. Each
// result, also each one flushed at the line end, waits for the shared 8-step
// divider that forms all four channel means, one quotient bit per cycle. A
// result that waits for pop holds the back end for as long as it waits. A
// blur of a whole image feeds rows first and then the columns of that result
// as lines.
module box_blur_line_filter
  import bbl_pkg::*;
#(
  parameter int MAX_RADIUS = 15
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        push,
  input  pix_in_t     pixel,
  output logic        full,
  output pix_out_t    result,
  output logic        empty,
  input  logic        pop
);

  logic [3:0] radius;
  logic       cfg_we;
  job_t       job;
  logic       job_valid;
  logic       job_take;

  // The only register is the radius, at addresses 0 to 3; addresses 4 to 7 read as zero.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {28'd0, radius} : 32'd0;

  // Radius is clamped to what the ring can hold.
  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= '0;
    end else if (cfg_we) begin
      if (int'(pwdata[3:0]) > MAX_RADIUS) begin
        radius <= 4'(MAX_RADIUS);
      end else begin
        radius <= pwdata[3:0];
      end
    end
  end

  bbl_front #(
    .MAX_RADIUS(MAX_RADIUS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .clear    (cfg_we),
    .radius   (radius),
    .push     (push),
    .pixel    (pixel),
    .full     (full),
    .job      (job),
    .job_valid(job_valid),
    .job_take (job_take)
  );

  bbl_back #(
    .MAX_RADIUS(MAX_RADIUS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .clear    (cfg_we),
    .radius   (radius),
    .job      (job),
    .job_valid(job_valid),
    .job_take (job_take),
    .result   (result),
    .empty    (empty),
    .pop      (pop)
  );

endmodule
